/* src/skmd_pkg.sv */
// ----------------------------------------------------------------------------
// skmd_pkg: split key matrix debouncer shared types and constants
// Field widths, register reset values and register index codes.
// ----------------------------------------------------------------------------
package skmd_pkg;

   localparam int LOCAL_ROWS_W  = 24;
   localparam int KEY_MATRIX_W  = 48;
   localparam int CNT_W         = 8;
   localparam int PRESSED_W     = 6;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   typedef logic [LOCAL_ROWS_W-1:0] rows_half_type;
   typedef logic [KEY_MATRIX_W-1:0] key_matrix_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [PRESSED_W-1:0]    pressed_type;
   typedef logic [CSR_INDEX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0]   csr_data_type;

   // register indexes
   localparam csr_index_type CSR_IS_LEFT_HAND     = 2'd0;
   localparam csr_index_type CSR_DEBOUNCE_SCANS   = 2'd1;
   localparam csr_index_type CSR_DISCONNECT_LIMIT = 2'd2;

   // reset values
   localparam logic    IS_LEFT_HAND_RST     = 1'b1;
   localparam cnt_type DEBOUNCE_SCANS_RST   = 8'd5;
   localparam cnt_type DISCONNECT_LIMIT_RST = 8'd5;
   localparam cnt_type ERR_CNT_MAX          = 8'hFF;

endpackage

/* src/skmd_req_if.sv */
// ----------------------------------------------------------------------------
// skmd_req_if: scan request channel
// Valid/ready channel carrying one scan period of local and remote rows.
// ----------------------------------------------------------------------------
interface skmd_req_if;
   import skmd_pkg::*;

   logic          valid;
   logic          ready;
   rows_half_type local_rows;
   logic          link_error;
   rows_half_type remote_rows;

   modport source (output valid, local_rows, link_error, remote_rows, input ready);
   modport sink   (input valid, local_rows, link_error, remote_rows, output ready);
endinterface

/* src/skmd_rsp_if.sv */
// ----------------------------------------------------------------------------
// skmd_rsp_if: scan result channel
// Valid/ready channel carrying the debounced matrix and status per scan.
// ----------------------------------------------------------------------------
interface skmd_rsp_if;
   import skmd_pkg::*;

   logic           valid;
   logic           ready;
   key_matrix_type key_matrix;
   logic           settled;
   logic           link_down_led;
   pressed_type    pressed_count;

   modport source (output valid, key_matrix, settled, link_down_led, pressed_count,
                   input ready);
   modport sink   (input valid, key_matrix, settled, link_down_led, pressed_count,
                   output ready);
endinterface

/* src/split_key_matrix_debouncer.sv */
// ----------------------------------------------------------------------------
// split_key_matrix_debouncer: split keyboard matrix scan with debounce
// Debounces the local half, merges the remote half under link supervision
// and reports the full matrix, a settled flag and the pressed key count.
// ----------------------------------------------------------------------------
//
//   channel  | direction | beat contents
//   ---------+-----------+---------------------------------------------------
//   req_ch   | in        | local_rows, link_error, remote_rows (one scan)
//   rsp_ch   | out       | key_matrix, settled, link_down_led, pressed_count
//   csr_*    | in        | write enable, register index, write data
//
// One scan beat per cycle sustained while rsp_ch.ready stays high. A beat is
// captured in the input register, then the state update and result are
// computed in one pass into the result register.
// Reset (synchronous) clears the matrix, raw rows and error count, loads the
// debounce counter and registers with their defaults.
// A stalled result holds the result register; the input register still
// takes one more beat, after which req_ch.ready drops until the result moves.
//
module split_key_matrix_debouncer #(
   parameter int ROWS_HALF = 4,
   parameter int COLUMNS   = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   skmd_req_if.sink                 req_ch,
   skmd_rsp_if.source               rsp_ch,
   input  logic                     csr_wr_en,
   input  skmd_pkg::csr_index_type  csr_index,
   input  skmd_pkg::csr_data_type   csr_wdata
);
   import skmd_pkg::*;

   localparam int ROWS_FULL = 2 * ROWS_HALF;
   localparam int LOC_W     = ROWS_HALF * COLUMNS;
   localparam int LOC_EXT_W = (LOC_W > LOCAL_ROWS_W) ? LOC_W : LOCAL_ROWS_W;
   localparam int FULL_W    = ROWS_FULL * COLUMNS;
   localparam int MAT_EXT_W = (FULL_W > KEY_MATRIX_W) ? FULL_W : KEY_MATRIX_W;

   // configuration registers
   logic    is_left_hand_ff;
   cnt_type debounce_scans_ff;
   cnt_type disconnect_limit_ff;

   // scan state
   logic [COLUMNS-1:0] raw_rows_ff [ROWS_HALF];
   logic [COLUMNS-1:0] raw_rows_in [ROWS_HALF];
   logic [COLUMNS-1:0] matrix_ff   [ROWS_FULL];
   logic [COLUMNS-1:0] matrix_in   [ROWS_FULL];
   cnt_type            db_cnt_ff, db_cnt_in;
   cnt_type            err_cnt_ff, err_cnt_in;

   // input register
   logic          in_valid_ff;
   rows_half_type in_local_rows_ff;
   logic          in_link_error_ff;
   rows_half_type in_remote_rows_ff;

   // result register
   logic           rsp_valid_ff;
   key_matrix_type rsp_key_matrix_ff, rsp_key_matrix_in;
   logic           rsp_settled_ff;
   logic           rsp_link_down_ff;
   pressed_type    rsp_pressed_ff;

   logic advance;
   logic req_take;

   // Advance the input beat whenever the result register is free or draining.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;

   // ---------------- configuration writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         is_left_hand_ff     <= IS_LEFT_HAND_RST;
         debounce_scans_ff   <= DEBOUNCE_SCANS_RST;
         disconnect_limit_ff <= DISCONNECT_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IS_LEFT_HAND:     is_left_hand_ff     <= csr_wdata[0];
            CSR_DEBOUNCE_SCANS:   debounce_scans_ff   <= csr_wdata;
            CSR_DISCONNECT_LIMIT: disconnect_limit_ff <= csr_wdata;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_local_rows_ff  <= req_ch.local_rows;
         in_link_error_ff  <= req_ch.link_error;
         in_remote_rows_ff <= req_ch.remote_rows;
      end
   end

   // ---------------- scan update ----------------
   logic [LOC_EXT_W-1:0] local_ext;
   logic [LOC_EXT_W-1:0] remote_ext;
   logic [FULL_W-1:0]    full_packed;
   logic [MAT_EXT_W-1:0] mat_ext;
   logic                 row_changed;
   cnt_type              reload;
   cnt_type              db_cnt_load;
   logic                 copy_local;
   logic                 clear_remote;

   // Rows past the 24-bit field read as zero.
   assign local_ext  = LOC_EXT_W'(in_local_rows_ff);
   assign remote_ext = LOC_EXT_W'(in_remote_rows_ff);

   // A zero reload acts as one so a change lands in the same scan.
   assign reload = (debounce_scans_ff == '0) ? cnt_type'(1) : debounce_scans_ff;

   always_comb begin
      row_changed = 1'b0;
      for (int i = 0; i < ROWS_HALF; i++) begin
         raw_rows_in[i] = local_ext[i*COLUMNS +: COLUMNS];
         if (raw_rows_in[i] != raw_rows_ff[i]) begin
            row_changed = 1'b1;
         end
      end
   end

   // Reload on any change, then count down; copy raw rows on reaching zero.
   always_comb begin
      db_cnt_load = row_changed ? reload : db_cnt_ff;
      copy_local  = 1'b0;
      db_cnt_in   = db_cnt_load;
      if (db_cnt_load != '0) begin
         db_cnt_in  = db_cnt_load - cnt_type'(1);
         copy_local = (db_cnt_load == cnt_type'(1));
      end
   end

   // Link supervision: saturating error count, clear remote half past limit.
   always_comb begin
      err_cnt_in   = '0;
      clear_remote = 1'b0;
      if (in_link_error_ff) begin
         err_cnt_in   = (err_cnt_ff == ERR_CNT_MAX) ? err_cnt_ff : err_cnt_ff + cnt_type'(1);
         clear_remote = (err_cnt_in > disconnect_limit_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < ROWS_HALF; i++) begin
         logic [COLUMNS-1:0] loc_old;
         logic [COLUMNS-1:0] rem_old;
         logic [COLUMNS-1:0] loc_new;
         logic [COLUMNS-1:0] rem_new;
         loc_old = is_left_hand_ff ? matrix_ff[i] : matrix_ff[ROWS_HALF + i];
         rem_old = is_left_hand_ff ? matrix_ff[ROWS_HALF + i] : matrix_ff[i];
         loc_new = copy_local ? raw_rows_in[i] : loc_old;
         if (!in_link_error_ff) begin
            rem_new = remote_ext[i*COLUMNS +: COLUMNS];
         end else if (clear_remote) begin
            rem_new = '0;
         end else begin
            rem_new = rem_old;
         end
         matrix_in[i]             = is_left_hand_ff ? loc_new : rem_new;
         matrix_in[ROWS_HALF + i] = is_left_hand_ff ? rem_new : loc_new;
      end
   end

   // Pack rows; anything past the 48-bit field is dropped.
   always_comb begin
      for (int i = 0; i < ROWS_FULL; i++) begin
         full_packed[i*COLUMNS +: COLUMNS] = matrix_in[i];
      end
   end
   assign mat_ext           = MAT_EXT_W'(full_packed);
   assign rsp_key_matrix_in = mat_ext[KEY_MATRIX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS_HALF; i++) begin
            raw_rows_ff[i] <= '0;
         end
         for (int i = 0; i < ROWS_FULL; i++) begin
            matrix_ff[i] <= '0;
         end
         db_cnt_ff  <= DEBOUNCE_SCANS_RST;
         err_cnt_ff <= '0;
      end else if (advance) begin
         raw_rows_ff <= raw_rows_in;
         matrix_ff   <= matrix_in;
         db_cnt_ff   <= db_cnt_in;
         err_cnt_ff  <= err_cnt_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_key_matrix_ff <= rsp_key_matrix_in;
         rsp_settled_ff    <= (db_cnt_in == '0);
         rsp_link_down_ff  <= in_link_error_ff;
         rsp_pressed_ff    <= PRESSED_W'($countones(rsp_key_matrix_in));
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.key_matrix    = rsp_key_matrix_ff;
   assign rsp_ch.settled       = rsp_settled_ff;
   assign rsp_ch.link_down_led = rsp_link_down_ff;
   assign rsp_ch.pressed_count = rsp_pressed_ff;

   // ---------------- assertions ----------------
   // A shown result's settled flag matches the counter it was computed from.
   a_settled_matches_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_settled_ff == (db_cnt_ff == '0)))
      else $error("settled flag disagrees with debounce counter");

   // A clean link exchange clears the error count.
   a_err_cnt_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && !in_link_error_ff |=> err_cnt_ff == '0)
      else $error("error count not cleared after good link beat");

   // A beat held in the input register is not lost while the result stalls.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_local_rows_ff))
      else $error("input beat dropped during stall");

   // Every advanced beat shows up in the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat missing from result register");

   // The key count reflects the shown matrix.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pressed_ff == PRESSED_W'($countones(rsp_key_matrix_ff)))
      else $error("pressed count disagrees with key matrix");

endmodule
